@@ src/assert_macros.svh @@
// Concurrent assertion helpers; a module that uses them provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/swmm_pkg.sv @@
`default_nettype none

package swmm_pkg;

  localparam int DATA_W     = 32;
  localparam int FILLED_W   = 7;
  localparam int WINDOW_DEF = 64;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DATA_W-1:0] SEED_MIN_RST = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] SEED_MAX_RST = 32'h0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_MAX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } swmm_state_t;

endpackage

`default_nettype wire

@@ src/sliding_window_min_max.sv @@
// An accepted sample goes through ST_CHECK and ST_DONE to its result beat, with
//   ST_SCAN between them when an evicted extreme forces a rescan of the ring
//   (one memory read per cycle). The next sample is taken only in ST_IDLE, after
//   the result register has been loaded, so a beat held by out_stall holds it off.
// Reset (rst, synchronous): ring slot and fill count zero, seeds at all ones
//   and zero, no result pending; ring contents are not cleared.
`default_nettype none

module sliding_window_min_max #(
  parameter int WINDOW = swmm_pkg::WINDOW_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [swmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [swmm_pkg::DATA_W-1:0]      cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [swmm_pkg::DATA_W-1:0]      sample,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [swmm_pkg::DATA_W-1:0]      window_min,
  output logic [swmm_pkg::DATA_W-1:0]      window_max,
  output logic [swmm_pkg::DATA_W-1:0]      amplitude,
  output logic [swmm_pkg::FILLED_W-1:0]    filled
);

  import swmm_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);

  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW);

  swmm_state_t state, state_next;

  logic [DATA_W-1:0] seed_min;
  logic [DATA_W-1:0] seed_max;
  logic [DATA_W-1:0] run_min;
  logic [DATA_W-1:0] run_max;
  logic [DATA_W-1:0] held_sample;
  logic [AW-1:0]     write_slot;
  logic [CW-1:0]     fill_count;
  logic [CW-1:0]     scan_cnt;
  logic              min_gone;
  logic              max_gone;

  logic [DATA_W-1:0] ring [WINDOW];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     raddr;
  logic              mem_we;

  logic              in_accept;
  logic              out_load;
  logic              full;
  logic              take_min;
  logic              take_max;
  logic              min_gone_c;
  logic              max_gone_c;
  logic [CW+FILLED_W-1:0] fill_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_min <= SEED_MIN_RST;
      seed_max <= SEED_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEED_MIN: seed_min <= cfg_data;
        REG_SEED_MAX: seed_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CHECK;
      ST_CHECK: state_next = (min_gone_c || max_gone_c) ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (scan_cnt == FULL_CNT) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    raddr    = write_slot;
    out_load = 1'b0;
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_CHECK: mem_we = 1'b1;
      ST_SCAN:  raddr = scan_cnt[AW-1:0];
      ST_DONE:  out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  assign full       = (fill_count == FULL_CNT);
  assign take_min   = (held_sample <= run_min);
  assign take_max   = (held_sample >= run_max);
  assign min_gone_c = full && (rd_data == run_min) && !take_min;
  assign max_gone_c = full && (rd_data == run_max) && !take_max;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[write_slot] <= held_sample;
    end
    rd_data <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      run_min    <= SEED_MIN_RST;
      run_max    <= SEED_MAX_RST;
      min_gone   <= 1'b0;
      max_gone   <= 1'b0;
      scan_cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          // Empty ring: restart the extremes from the seeds.
          if (in_accept && (fill_count == '0)) begin
            run_min <= seed_min;
            run_max <= seed_max;
          end
        end
        ST_CHECK: begin
          if (min_gone_c) begin
            run_min <= seed_min;
          end else if (take_min) begin
            run_min <= held_sample;
          end
          if (max_gone_c) begin
            run_max <= seed_max;
          end else if (take_max) begin
            run_max <= held_sample;
          end
          min_gone   <= min_gone_c;
          max_gone   <= max_gone_c;
          write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
          if (!full) begin
            fill_count <= fill_count + CW'(1);
          end
          scan_cnt <= '0;
        end
        ST_SCAN: begin
          // Read data is registered: it belongs to the address issued in the cycle before.
          if (scan_cnt != '0) begin
            if (min_gone && (rd_data < run_min)) run_min <= rd_data;
            if (max_gone && (rd_data > run_max)) run_max <= rd_data;
          end
          if (scan_cnt != FULL_CNT) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      held_sample <= sample;
    end
  end

  assign fill_ext = (CW + FILLED_W)'(fill_count);

  // Result register: hold the beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      window_min <= run_min;
      window_max <= run_max;
      amplitude  <= run_max - run_min;
      filled     <= fill_ext[FILLED_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/swmm_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module swmm_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire [swmm_pkg::DATA_W-1:0]     window_min,
  input wire [swmm_pkg::DATA_W-1:0]     window_max,
  input wire [swmm_pkg::DATA_W-1:0]     amplitude,
  input wire [swmm_pkg::FILLED_W-1:0]   filled
);

  import swmm_pkg::*;

  logic [DATA_W-1:0] span;

  assign span = window_max - window_min;

  // No result beat may survive a reset.
  `ASSERT_ALWAYS(a_rst_no_result, rst |=> !out_valid, "result beat pending after reset")

  // A sample beat keeps the block busy for at least the next cycle.
  `ASSERT_CLK(a_busy_after_beat, (in_valid && !in_stall) |=> in_stall, "sample taken back to back")

  `ASSERT_CLK(a_amplitude, out_valid |-> (amplitude == span), "amplitude differs from max - min")

  // Hold a stalled result beat.
  `ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(window_min) && $stable(window_max) && $stable(filled)), "stalled result beat changed")

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (.*);

`default_nettype wire

@@ test/tb_sliding_window_min_max.sv @@
`default_nettype none

module tb_sliding_window_min_max;
  timeunit 1ns;
  timeprecision 1ps;

  import swmm_pkg::*;

  localparam int WIN          = WINDOW_DEF;
  localparam int PHASE_ITEMS  = 255;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 1_000_000;

  typedef struct packed {
    logic [DATA_W-1:0]   lo;
    logic [DATA_W-1:0]   hi;
    logic [DATA_W-1:0]   span;
    logic [FILLED_W-1:0] count;
  } window_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              typed;
    window_t           want;
  } sample_row_t;

  typedef enum int {
    MODE_SPREAD,
    MODE_NARROW,
    MODE_RISING,
    MODE_FALLING,
    MODE_EDGES
  } sample_mode_t;

  localparam logic [DATA_W-1:0] EDGE_VALUES [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  // Seeds during this table: minimum all ones, maximum 0x1000.
  localparam int N_ROWS = 16;
  localparam sample_row_t SAMPLE_ROWS [N_ROWS] = '{
    '{32'h0000_0800, 1'b1, '{32'h0000_0800, 32'h0000_1000, 32'h0000_0800, 7'd1}},
    '{32'hFFFF_FFFF, 1'b1, '{32'h0000_0800, 32'hFFFF_FFFF, 32'hFFFF_F7FF, 7'd2}},
    '{32'h0000_0000, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd3}},
    '{32'h0000_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h0000_0001, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, '0},
    '{32'h0000_1000, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b0, '0},
    '{32'h0F0F_0F0F, 1'b0, '0},
    '{32'hF0F0_F0F0, 1'b0, '0}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEED_MIN;
  logic [DATA_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    sample    = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    window_min;
  logic [DATA_W-1:0]    window_max;
  logic [DATA_W-1:0]    amplitude;
  logic [FILLED_W-1:0]  filled;

  logic idle_on  = 1'b1;
  logic hold_go  = 1'b0;
  logic hold_off = 1'b0;

  // Predictor state
  logic [DATA_W-1:0] ring_mem [WIN];
  int                next_slot = 0;
  int                held      = 0;
  logic [DATA_W-1:0] cur_min   = SEED_MIN_RST;
  logic [DATA_W-1:0] cur_max   = SEED_MAX_RST;
  logic [DATA_W-1:0] seed_lo   = SEED_MIN_RST;
  logic [DATA_W-1:0] seed_hi   = SEED_MAX_RST;

  window_t pending_windows [$];
  window_t head;
  int      mismatches = 0;

  sliding_window_min_max #(.WINDOW(WIN)) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_min (window_min),
    .window_max (window_max),
    .amplitude  (amplitude),
    .filled     (filled)
  );

  always #5 clk = ~clk;

  function automatic window_t slide_window(logic [DATA_W-1:0] s);
    logic    min_lost;
    logic    max_lost;
    window_t r;
    min_lost = 1'b0;
    max_lost = 1'b0;
    if (held == 0) begin
      cur_min = seed_lo;
      cur_max = seed_hi;
    end
    if (held >= WIN) begin
      min_lost = (ring_mem[next_slot] == cur_min);
      max_lost = (ring_mem[next_slot] == cur_max);
    end
    // a tie takes the extreme over, so no rescan for it
    if (s <= cur_min) begin
      min_lost = 1'b0;
      cur_min  = s;
    end
    if (s >= cur_max) begin
      max_lost = 1'b0;
      cur_max  = s;
    end
    ring_mem[next_slot] = s;
    if (held < WIN) held++;
    next_slot = (next_slot == WIN - 1) ? 0 : next_slot + 1;
    if (min_lost) begin
      cur_min = seed_lo;
      foreach (ring_mem[i]) if (ring_mem[i] < cur_min) cur_min = ring_mem[i];
    end
    if (max_lost) begin
      cur_max = seed_hi;
      foreach (ring_mem[i]) if (ring_mem[i] > cur_max) cur_max = ring_mem[i];
    end
    r.lo    = cur_min;
    r.hi    = cur_max;
    r.span  = cur_max - cur_min;
    r.count = held[FILLED_W-1:0];
    return r;
  endfunction

  // Call at a clock edge; returns at the edge that accepts the beat.
  task automatic send_sample(input logic [DATA_W-1:0] v, input logic typed,
                             input window_t want);
    window_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (in_stall);
    got = slide_window(v);
    pending_windows.push_back(typed ? want : got);
  endtask

  task automatic load_seeds(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SEED_MIN;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    seed_lo = lo;
    cfg_index <= REG_SEED_MAX;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    seed_hi = hi;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_windows.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                           input logic squeeze, input logic quiet);
    int                left;
    int                len;
    sample_mode_t      mode;
    logic [DATA_W-1:0] walk;
    logic [DATA_W-1:0] v;
    wait_drained();
    load_seeds(lo, hi);
    if (squeeze) hold_go <= 1'b1;
    if (quiet) idle_on <= 1'b0;
    left = PHASE_ITEMS;
    while (left > 0) begin
      mode = sample_mode_t'($urandom_range(0, 4));
      len  = $urandom_range(16, 96);
      if (len > left) len = left;
      walk = $urandom();
      repeat (len) begin
        case (mode)
          MODE_SPREAD: v = $urandom();
          MODE_NARROW: v = walk + $urandom_range(0, 3);
          MODE_RISING: begin
            walk = walk + $urandom_range(0, 3);
            v    = walk;
          end
          MODE_FALLING: begin
            walk = walk - $urandom_range(0, 3);
            v    = walk;
          end
          default: v = EDGE_VALUES[$urandom_range(0, 5)];
        endcase
        send_sample(v, 1'b0, '0);
      end
      left -= len;
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus the long hold-off.
  initial begin : rx_side
    int rx_left;
    rx_left = 0;
    forever begin
      @(posedge clk);
      if (rx_left == 0 && idle_on && $urandom_range(0, 5) == 0)
        rx_left = $urandom_range(1, 11);
      out_stall <= hold_off || (rx_left != 0);
      if (rx_left != 0) rx_left--;
    end
  end

  initial begin : long_hold
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        head = pending_windows.pop_front();
        if (window_min !== head.lo) begin
          $error("window_min: expected %h, got %h", head.lo, window_min);
          mismatches++;
        end
        if (window_max !== head.hi) begin
          $error("window_max: expected %h, got %h", head.hi, window_max);
          mismatches++;
        end
        if (amplitude !== head.span) begin
          $error("amplitude: expected %h, got %h", head.span, amplitude);
          mismatches++;
        end
        if (filled !== head.count) begin
          $error("filled: expected %0d, got %0d", head.count, filled);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("sliding_window_min_max verification failed");
    $finish;
  end

  initial begin : main_seq
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // seed maximum is live at once while the ring is empty
    load_seeds(32'hFFFF_FFFF, 32'h0000_1000);
    for (int r = 0; r < N_ROWS; r++)
      send_sample(SAMPLE_ROWS[r].value, SAMPLE_ROWS[r].typed, SAMPLE_ROWS[r].want);
    in_valid <= 1'b0;

    run_phase(32'hFFFF_FFFF, 32'h0000_1000, 1'b0, 1'b0);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
    run_phase($urandom(),    $urandom(),    1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    run_phase(32'h0000_0100, 32'hFFFF_0000, 1'b0, 1'b0);
    run_phase($urandom(),    $urandom(),    1'b0, 1'b1);

    wait_drained();
    // catch stray beats
    repeat (WIN + 8) @(posedge clk);
    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("sliding_window_min_max verification clean");
    end else begin
      $display("sliding_window_min_max verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+src
src/swmm_pkg.sv
src/sliding_window_min_max.sv
src/swmm_checker.sv
test/tb_sliding_window_min_max.sv
